@@ rtl/bvce_pkg.sv @@
// Shared types and constants for the S-curve step rate evaluator.
// Depends on nothing; used by bezier_velocity_curve_eval.
package bvce_pkg;

   // Width of the curve parameter t and of the step index (unsigned Q0.32).
   localparam int T_W = 32;

   // Configuration port: byte addresses 0, 4 and 8, so four address bits.
   localparam int ADDR_W = 4;
   localparam int DATA_W = 32;

   // Monomial weights with the common factor of 128 taken out:
   // A = 128*6*(end-start), B = -128*15*(end-start), C = 128*10*(end-start).
   localparam int C3_SCALE = 10;
   localparam int C4_SCALE = 15;
   localparam int C5_SCALE = 6;

   // 38 - 7: the factor of 128 is already folded out of the weights.
   localparam int ACC_SHIFT = 31;

   // Number of register stages from an accepted item to its result.
   localparam int STAGES = 7;

   typedef enum logic [1:0] {
      REG_START_RATE = 2'd0,
      REG_END_RATE   = 2'd1,
      REG_ADVANCE    = 2'd2
   } reg_index_type;

endpackage

@@ rtl/bezier_velocity_curve_eval.sv @@
// S-curve step rate evaluator: quintic smooth-step velocity profile in fixed point.
// Depends on bvce_pkg for register codes, weights and pipeline constants.
//
// Usage: software programs start_rate, end_rate and advance_per_step over the
// APB-style port (byte addresses 0, 4 and 8) while the block is idle. Then a step
// index is offered on req_step_index with start high; an item is taken at every
// rising edge where start is high and busy is low. busy is always low, because the
// datapath is a fixed pipeline that takes one new item every clock cycle.
//
// Each item produces exactly one result. rsp_valid rises when that result reaches
// the last stage register and stays high for one cycle with it on rsp_rate.
// Results leave in the order that items came in. The receiver cannot stall the
// block, so no backpressure path exists and nothing is ever held back.
//
// The seven stages are: t = advance*index (low word), then t^2, t^3, t^4 and t^5,
// each the high word of one 32x32 product, then the three weighted terms, each one
// multiply, and finally the sum with start_rate and the arithmetic shift by 31.
// The depth is set by that chain of dependent multiplies and the closing sum.
//
// A synchronous, active-high reset clears the pipeline valid bits, so no result
// comes out of items that were in flight, and it returns every configuration and
// weight register to zero. The datapath registers are not reset.
// The weight registers follow the rate registers in the cycle after a write.

module bezier_velocity_curve_eval #(
   parameter int RATE_WIDTH = 18
) (
   input  logic                                clock,
   input  logic                                reset,
   // Input channel.
   input  logic                                start,
   output logic                                busy,
   input  logic [bvce_pkg::T_W-1:0]            req_step_index,
   // Result channel.
   output logic                                rsp_valid,
   output logic signed [RATE_WIDTH:0]          rsp_rate,
   // Configuration port.
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [bvce_pkg::ADDR_W-1:0]         paddr,
   input  logic [bvce_pkg::DATA_W-1:0]         pwdata,
   output logic [bvce_pkg::DATA_W-1:0]         prdata,
   output logic                                pready
);

   localparam int TW     = bvce_pkg::T_W;
   localparam int NS     = bvce_pkg::STAGES;
   // Signed difference end-start needs one bit more than a rate.
   localparam int DW     = RATE_WIDTH + 1;
   // Weights up to 15 times the difference need four more bits.
   localparam int CW     = DW + 4;
   // A 31-bit power of t (held as 32-bit signed) times a weight.
   localparam int PW     = TW + CW;
   // start_rate<<31 plus three terms, with headroom for the carries.
   localparam int ACC_W  = PW + 3;

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [RATE_WIDTH-1:0]    start_rate_ff, start_rate_in;
   logic [RATE_WIDTH-1:0]    end_rate_ff,   end_rate_in;
   logic [TW-1:0]            advance_ff,    advance_in;
   logic                     cfg_write;
   bvce_pkg::reg_index_type  cfg_index;

   assign pready    = 1'b1;
   assign busy      = 1'b0;
   assign cfg_write = psel && penable && pwrite;
   assign cfg_index = bvce_pkg::reg_index_type'(paddr[bvce_pkg::ADDR_W-1:2]);

   always_comb begin
      start_rate_in = start_rate_ff;
      end_rate_in   = end_rate_ff;
      advance_in    = advance_ff;
      if (cfg_write) begin
         case (cfg_index)
            bvce_pkg::REG_START_RATE: start_rate_in = pwdata[RATE_WIDTH-1:0];
            bvce_pkg::REG_END_RATE:   end_rate_in   = pwdata[RATE_WIDTH-1:0];
            bvce_pkg::REG_ADVANCE:    advance_in    = pwdata[TW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (cfg_index)
         bvce_pkg::REG_START_RATE:
            prdata = bvce_pkg::DATA_W'(start_rate_ff);
         bvce_pkg::REG_END_RATE:
            prdata = bvce_pkg::DATA_W'(end_rate_ff);
         bvce_pkg::REG_ADVANCE:
            prdata = bvce_pkg::DATA_W'(advance_ff);
         default:
            prdata = '0;
      endcase
   end

   // Weights derived from the rate registers, registered so the product stage
   // sees a plain register operand.
   logic signed [DW-1:0]     diff;
   logic signed [CW-1:0]     diff_ext;
   logic signed [CW-1:0]     k3_ff, k3_in;
   logic signed [CW-1:0]     k4_ff, k4_in;
   logic signed [CW-1:0]     k5_ff, k5_in;

   assign diff     = $signed({1'b0, end_rate_ff}) - $signed({1'b0, start_rate_ff});
   assign diff_ext = CW'(diff);
   assign k3_in    = diff_ext * CW'(bvce_pkg::C3_SCALE);
   assign k4_in    = CW'(0) - diff_ext * CW'(bvce_pkg::C4_SCALE);
   assign k5_in    = diff_ext * CW'(bvce_pkg::C5_SCALE);

   always_ff @(posedge clock) begin
      if (reset) begin
         start_rate_ff <= '0;
         end_rate_ff   <= '0;
         advance_ff    <= '0;
         k3_ff         <= '0;
         k4_ff         <= '0;
         k5_ff         <= '0;
      end else begin
         start_rate_ff <= start_rate_in;
         end_rate_ff   <= end_rate_in;
         advance_ff    <= advance_in;
         k3_ff         <= k3_in;
         k4_ff         <= k4_in;
         k5_ff         <= k5_in;
      end
   end

   // ------------------------------------------------------------------
   // Pipeline valid bits
   // ------------------------------------------------------------------
   logic [NS-1:0] valid_ff, valid_in;
   logic          accept;

   assign accept   = start && !busy;
   assign valid_in = {valid_ff[NS-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // ------------------------------------------------------------------
   // Datapath
   // ------------------------------------------------------------------
   // Stage 0: curve parameter, wrapping modulo 2^32.
   logic [TW-1:0]    s0_t_ff, s0_t_in;
   // Stage 1: t^2.
   logic [2*TW-1:0]  m1;
   logic [TW-1:0]    s1_t_ff, s1_t2_ff, s1_t2_in;
   // Stage 2: t^3.
   logic [2*TW-1:0]  m2;
   logic [TW-1:0]    s2_t_ff, s2_t3_ff, s2_t3_in;
   // Stage 3: t^4.
   logic [2*TW-1:0]  m3;
   logic [TW-1:0]    s3_t_ff, s3_t3_ff, s3_t4_ff, s3_t4_in;
   // Stage 4: t^5.
   logic [2*TW-1:0]  m4;
   logic [TW-1:0]    s4_t3_ff, s4_t4_ff, s4_t5_ff, s4_t5_in;
   // Stage 5: weighted terms.
   logic signed [TW-1:0] h3, h4, h5;
   logic signed [PW-1:0] s5_p3_ff, s5_p3_in;
   logic signed [PW-1:0] s5_p4_ff, s5_p4_in;
   logic signed [PW-1:0] s5_p5_ff, s5_p5_in;
   // Stage 6: sum and scale.
   logic signed [ACC_W-1:0] acc;
   logic [RATE_WIDTH:0]     s6_rate_ff, s6_rate_in;

   assign s0_t_in  = advance_ff * req_step_index;

   assign m1       = {{TW{1'b0}}, s0_t_ff} * {{TW{1'b0}}, s0_t_ff};
   assign s1_t2_in = m1[2*TW-1:TW];

   assign m2       = {{TW{1'b0}}, s1_t2_ff} * {{TW{1'b0}}, s1_t_ff};
   assign s2_t3_in = m2[2*TW-1:TW];

   assign m3       = {{TW{1'b0}}, s2_t3_ff} * {{TW{1'b0}}, s2_t_ff};
   assign s3_t4_in = m3[2*TW-1:TW];

   assign m4       = {{TW{1'b0}}, s3_t4_ff} * {{TW{1'b0}}, s3_t_ff};
   assign s4_t5_in = m4[2*TW-1:TW];

   // Each power drops its lowest bit and is used as a non-negative signed value.
   assign h3       = $signed({1'b0, s4_t3_ff[TW-1:1]});
   assign h4       = $signed({1'b0, s4_t4_ff[TW-1:1]});
   assign h5       = $signed({1'b0, s4_t5_ff[TW-1:1]});
   assign s5_p3_in = PW'(h3) * PW'(k3_ff);
   assign s5_p4_in = PW'(h4) * PW'(k4_ff);
   assign s5_p5_in = PW'(h5) * PW'(k5_ff);

   // The arithmetic shift followed by truncation is a plain part-select.
   assign acc = $signed({{(ACC_W-RATE_WIDTH-bvce_pkg::ACC_SHIFT){1'b0}}, start_rate_ff,
                         {bvce_pkg::ACC_SHIFT{1'b0}}})
              + ACC_W'(s5_p3_ff) + ACC_W'(s5_p4_ff) + ACC_W'(s5_p5_ff);
   assign s6_rate_in = acc[bvce_pkg::ACC_SHIFT +: RATE_WIDTH + 1];

   always_ff @(posedge clock) begin
      s0_t_ff    <= s0_t_in;

      s1_t_ff    <= s0_t_ff;
      s1_t2_ff   <= s1_t2_in;

      s2_t_ff    <= s1_t_ff;
      s2_t3_ff   <= s2_t3_in;

      s3_t_ff    <= s2_t_ff;
      s3_t3_ff   <= s2_t3_ff;
      s3_t4_ff   <= s3_t4_in;

      s4_t3_ff   <= s3_t3_ff;
      s4_t4_ff   <= s3_t4_ff;
      s4_t5_ff   <= s4_t5_in;

      s5_p3_ff   <= s5_p3_in;
      s5_p4_ff   <= s5_p4_in;
      s5_p5_ff   <= s5_p5_in;

      s6_rate_ff <= s6_rate_in;
   end

   assign rsp_valid = valid_ff[NS-1];
   assign rsp_rate  = $signed(s6_rate_ff);

endmodule

@@ verif/tb_bezier_velocity_curve_eval.sv @@
// Self-checking testbench for the S-curve step rate evaluator.
// Needs only bvce_pkg and bezier_velocity_curve_eval; it predicts every rate itself.
`timescale 1ns / 1ps

module tb_bezier_velocity_curve_eval;

   // The block runs at its default rate width. Every width below follows from it.
   localparam int RATE_W = 18;
   localparam logic [RATE_W-1:0] RATE_MAX = {RATE_W{1'b1}};

   // No register sits behind the fourth word address. Writes there must be dropped.
   localparam logic [1:0] REG_UNUSED = 2'd3;

   // CYCLE_LIMIT is far above what the slowest correct run needs, with about 700
   // items, random gaps at 47 percent, register writes and drains.
   localparam int CYCLE_LIMIT = 200_000;

   // One predicted result, with the step index kept for the error report.
   typedef struct {
      logic [bvce_pkg::T_W-1:0] index;
      logic signed [RATE_W:0]   rate;
   } rate_entry_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        start = 1'b0;
   logic                        busy;
   logic [bvce_pkg::T_W-1:0]    req_step_index = '0;
   logic                        rsp_valid;
   logic signed [RATE_W:0]      rsp_rate;
   logic                        psel = 1'b0;
   logic                        penable = 1'b0;
   logic                        pwrite = 1'b0;
   logic [bvce_pkg::ADDR_W-1:0] paddr = '0;
   logic [bvce_pkg::DATA_W-1:0] pwdata = '0;
   logic [bvce_pkg::DATA_W-1:0] prdata;
   logic                        pready;

   // Our own copy of the three registers, updated whenever a write completes.
   logic [RATE_W-1:0]           cfg_start = '0;
   logic [RATE_W-1:0]           cfg_end = '0;
   logic [bvce_pkg::T_W-1:0]    cfg_advance = '0;

   // Rates still owed by the block, oldest first.
   rate_entry_type              pending_rates[$];

   int                          fail_count = 0;
   int                          items_sent = 0;
   int                          settings_used = 0;
   int                          cycle_count = 0;

   bezier_velocity_curve_eval #(
      .RATE_WIDTH(RATE_W)
   ) u_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_step_index (req_step_index),
      .rsp_valid      (rsp_valid),
      .rsp_rate       (rsp_rate),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   always #2 clock = ~clock;

   // A hung handshake or a lost result must not stall the run forever.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: run stopped after %0d cycles with %0d rates outstanding",
                  $time, cycle_count, pending_rates.size());
         $display("bezier_velocity_curve_eval: mismatch");
         $finish;
      end
   end

   // Step rate of the quintic smooth-step profile at one step index, from the
   // current register copy. The curve parameter t is the low word of
   // advance*index read as Q0.32, and its powers keep the high word of each
   // product. All weights share a factor of 128, so the sum is formed at
   // 1/128 scale and shifted by 31 instead of 38. The shift floors, which is
   // how a result can land one unit below the lower rate, even at -1.
   function automatic logic signed [RATE_W:0] predict_rate(
         input logic [bvce_pkg::T_W-1:0] index);
      logic [63:0]            t1;
      logic [63:0]            t2;
      logic [63:0]            t3;
      logic [63:0]            t4;
      logic [63:0]            t5;
      longint                 span;
      longint                 sum;
      logic signed [RATE_W:0] rate;
      t1 = ({32'd0, cfg_advance} * {32'd0, index}) & 64'h0000_0000_FFFF_FFFF;
      t2 = (t1 * t1) >> 32;
      t3 = (t2 * t1) >> 32;
      t4 = (t3 * t1) >> 32;
      t5 = (t4 * t1) >> 32;
      span = longint'(cfg_end) - longint'(cfg_start);
      sum = longint'(cfg_start) <<< bvce_pkg::ACC_SHIFT;
      sum += longint'(t3 >> 1) * (bvce_pkg::C3_SCALE * span);
      sum -= longint'(t4 >> 1) * (bvce_pkg::C4_SCALE * span);
      sum += longint'(t5 >> 1) * (bvce_pkg::C5_SCALE * span);
      rate = sum[bvce_pkg::ACC_SHIFT +: RATE_W + 1];
      return rate;
   endfunction

   // The readback value of a register: its stored bits, zero above its width.
   function automatic logic [bvce_pkg::DATA_W-1:0] register_value(input logic [1:0] index);
      case (index)
         bvce_pkg::REG_START_RATE: return bvce_pkg::DATA_W'(cfg_start);
         bvce_pkg::REG_END_RATE:   return bvce_pkg::DATA_W'(cfg_end);
         bvce_pkg::REG_ADVANCE:    return bvce_pkg::DATA_W'(cfg_advance);
         default:                  return '0;
      endcase
   endfunction

   // Every rate on the result port is compared against the oldest prediction.
   // An X on the strobe is reported as well rather than silently skipped.
   always @(posedge clock) begin : check_rates
      rate_entry_type head;
      if (!reset && rsp_valid !== 1'b0) begin
         if (pending_rates.size() == 0) begin
            $display("%0t: unexpected rate: expected none, got %0d (valid %b)",
                     $time, rsp_rate, rsp_valid);
            fail_count++;
         end else begin
            head = pending_rates.pop_front();
            if (rsp_valid !== 1'b1 || rsp_rate !== head.rate) begin
               $display("%0t: rate for step index 0x%08h: expected %0d, got %0d (valid %b)",
                        $time, head.index, head.rate, rsp_rate, rsp_valid);
               fail_count++;
            end
         end
      end
   end

   // Register write: setup cycle, access cycle, then a cycle with the port
   // released so that back-to-back calls never reassign psel in one step.
   task automatic csr_write(input logic [1:0] index,
                            input logic [bvce_pkg::DATA_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      case (index)
         bvce_pkg::REG_START_RATE: cfg_start = data[RATE_W-1:0];
         bvce_pkg::REG_END_RATE:   cfg_end = data[RATE_W-1:0];
         bvce_pkg::REG_ADVANCE:    cfg_advance = data[bvce_pkg::T_W-1:0];
         default:                  ;
      endcase
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // Register read, checked against the register copy. prdata is sampled at
   // the edge that completes the access.
   task automatic csr_check(input logic [1:0] index);
      logic [bvce_pkg::DATA_W-1:0] value;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {index, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      value = prdata;
      if (value !== register_value(index)) begin
         $display("%0t: register %0d readback: expected 0x%08h, got 0x%08h",
                  $time, index, register_value(index), value);
         fail_count++;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // Offers one step index, after a random gap when idle_pct is nonzero. start
   // stays high from one item to the next when there is no gap.
   task automatic send_step(input logic [bvce_pkg::T_W-1:0] index, input int idle_pct);
      rate_entry_type entry;
      if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      start          <= 1'b1;
      req_step_index <= index;
      @(posedge clock);
      while (busy) @(posedge clock);
      entry.index = index;
      entry.rate  = predict_rate(index);
      pending_rates.push_back(entry);
      items_sent++;
   endtask

   // Stops sending and waits for every owed rate, then lets the pipeline
   // depth go by so the block is quiet before any register changes.
   task automatic wait_rates_drained();
      start <= 1'b0;
      while (pending_rates.size() != 0) @(posedge clock);
      repeat (bvce_pkg::STAGES + 2) @(posedge clock);
   endtask

   task automatic apply_setting(input logic [RATE_W-1:0] start_rate,
                                input logic [RATE_W-1:0] end_rate,
                                input logic [bvce_pkg::T_W-1:0] advance);
      wait_rates_drained();
      csr_write(bvce_pkg::REG_START_RATE, bvce_pkg::DATA_W'(start_rate));
      csr_write(bvce_pkg::REG_END_RATE, bvce_pkg::DATA_W'(end_rate));
      csr_write(bvce_pkg::REG_ADVANCE, advance);
      settings_used++;
   endtask

   // Reset values, full-width writes that spill above the rate width, and a
   // write to the unused address that must leave everything alone.
   task automatic test_register_access();
      csr_check(bvce_pkg::REG_START_RATE);
      csr_check(bvce_pkg::REG_END_RATE);
      csr_check(bvce_pkg::REG_ADVANCE);
      // With everything at zero the curve is flat at zero.
      send_step(32'h0000_0000, 0);
      send_step(32'hFFFF_FFFF, 0);
      wait_rates_drained();
      csr_write(bvce_pkg::REG_START_RATE, 32'hFFFF_FFFF);
      csr_write(bvce_pkg::REG_END_RATE, 32'hFFFC_0000);
      csr_write(bvce_pkg::REG_ADVANCE, 32'hFFFF_FFFF);
      csr_check(bvce_pkg::REG_START_RATE);
      csr_check(bvce_pkg::REG_END_RATE);
      csr_check(bvce_pkg::REG_ADVANCE);
      csr_write(REG_UNUSED, 32'hA5A5_A5A5);
      csr_check(bvce_pkg::REG_START_RATE);
      csr_check(bvce_pkg::REG_END_RATE);
      csr_check(bvce_pkg::REG_ADVANCE);
      csr_write(bvce_pkg::REG_START_RATE, 32'h0000_0000);
      csr_write(bvce_pkg::REG_END_RATE, 32'h0003_FFFF);
      csr_write(bvce_pkg::REG_ADVANCE, 32'h0000_0000);
      csr_check(bvce_pkg::REG_START_RATE);
      csr_check(bvce_pkg::REG_END_RATE);
      csr_check(bvce_pkg::REG_ADVANCE);
      settings_used++;
   endtask

   // Short list of hand-picked points on the curve.
   task automatic test_directed_cases();
      // Full rising span, largest advance: t = 0, t just under 1 and t tiny.
      apply_setting('0, RATE_MAX, 32'hFFFF_FFFF);
      send_step(32'h0000_0000, 0);
      send_step(32'h0000_0001, 0);
      send_step(32'hFFFF_FFFF, 0);
      send_step(32'h0000_0002, 0);
      send_step(32'h8000_0000, 0);
      // Falling to zero with t at its top: truncation can dip the rate to -1.
      apply_setting(RATE_MAX, '0, 32'h0000_0001);
      send_step(32'hFFFF_FFFF, 0);
      send_step(32'hFFFF_FFFE, 0);
      send_step(32'h8000_0000, 0);
      send_step(32'h0000_0000, 0);
      send_step(32'h0000_0001, 0);
      // Half-turn advance: index 2 wraps t back to exactly zero.
      apply_setting(18'd1000, 18'd200000, 32'h8000_0000);
      send_step(32'h0000_0001, 0);
      send_step(32'h0000_0002, 0);
      send_step(32'h0000_0003, 0);
      send_step(32'h5555_5555, 0);
      send_step(32'hAAAA_AAAA, 0);
      // No advance at all: the rate stays at the start value.
      apply_setting(18'd123456, 18'd7, 32'h0000_0000);
      send_step(32'hFFFF_FFFF, 0);
      send_step(32'h1234_5678, 0);
      // Equal rates give a flat curve at the top of the range.
      apply_setting(RATE_MAX, RATE_MAX, 32'h0123_4567);
      send_step(32'hFFFF_FFFF, 0);
      send_step(32'h0000_0100, 0);
      send_step(32'h00F0_0F0F, 0);
   endtask

   // The sender holds off until every result is back, then resumes mid-move.
   task automatic test_drain_pause();
      apply_setting(18'd5000, 18'd250000, 32'h0100_0000);
      for (int k = 0; k < 20; k++) send_step(bvce_pkg::T_W'(k), 0);
      wait_rates_drained();
      for (int k = 20; k < 40; k++) send_step(bvce_pkg::T_W'(k), 14);
   endtask

   // Noise between well-formed moves: any index, or one near either end.
   function automatic logic [bvce_pkg::T_W-1:0] noise_index();
      case ($urandom_range(2))
         0:       return $urandom_range(63);
         1:       return 32'hFFFF_FFFF - $urandom_range(63);
         default: return $urandom;
      endcase
   endfunction

   // Mostly whole moves: advance is about 2^32 divided by the step count (random
   // in the last setting) and indices count up from zero, past the end of moves
   // under 100 steps so t wraps. One in six is noise; settings share 3 idle rates.
   task automatic test_random_moves();
      int                       idle_pcts[3];
      logic [RATE_W-1:0]        start_rate;
      logic [RATE_W-1:0]        end_rate;
      logic [bvce_pkg::T_W-1:0] advance;
      int                       steps;
      logic [bvce_pkg::T_W-1:0] index;
      idle_pcts = '{0, 47, 14};
      for (int b = 0; b < 6; b++) begin
         case (b)
            0: begin
               start_rate = '0;
               end_rate = RATE_MAX;
            end
            1: begin
               start_rate = RATE_MAX;
               end_rate = '0;
            end
            2: begin
               start_rate = RATE_W'($urandom);
               end_rate = start_rate;
            end
            default: begin
               start_rate = RATE_W'($urandom);
               end_rate = RATE_W'($urandom);
            end
         endcase
         steps = $urandom_range(40, 160);
         advance = (b == 5) ? bvce_pkg::T_W'($urandom)
                            : bvce_pkg::T_W'((64'd1 << 32) / steps);
         apply_setting(start_rate, end_rate, advance);
         for (int k = 0; k < 100; k++) begin
            index = ($urandom_range(5) == 0) ? noise_index() : bvce_pkg::T_W'(k);
            send_step(index, idle_pcts[b % 3]);
         end
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_register_access();
      test_directed_cases();
      test_drain_pause();
      test_random_moves();
      wait_rates_drained();
      $display("Checked %0d step rates across %0d register settings, including wrap,",
               items_sent, settings_used);
      $display("end-of-curve undershoot, flat curves and sender gaps of 0, 14 and 47 percent.");
      if (fail_count == 0) begin
         $display("bezier_velocity_curve_eval: match");
      end else begin
         $display("bezier_velocity_curve_eval: mismatch");
      end
      $finish;
   end

endmodule
